// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the grid path-sum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define GMPS_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: invariant failed");

// An antecedent that must be followed by a consequent in the next cycle.
`define GMPS_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: rtl/gmps_pkg.sv
// Package for the grid path-sum block: widths, register indexes and cell control type.
package gmps_pkg;

    localparam int unsigned COST_W     = 16;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned ROW_W      = 16;
    localparam int unsigned GCOL_W     = 11;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t CFG_GRID_COLS = 1'b0;
    localparam cfg_index_t CFG_GRID_ROWS = 1'b1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Control handed to each cell of the row chain.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

// File: rtl/gmps_cell.sv
// One cell of the row chain: holds one previous-row sum and passes it on.
module gmps_cell
(
    input  logic                           clk,
    input  gmps_pkg::cell_ctl_t            ctl,
    input  logic [gmps_pkg::SUM_W-1:0]     new_sum,
    input  logic [gmps_pkg::SUM_W-1:0]     prev_sum,
    output logic [gmps_pkg::SUM_W-1:0]     sum
);

    logic [gmps_pkg::SUM_W-1:0] sum_reg;

    // On every accepted request the cell either takes the fresh sum (head of
    // the chain) or the value of its upstream neighbour.
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            sum_reg <= ctl.load ? new_sum : prev_sum;
        end
    end

    assign sum = sum_reg;

endmodule

// File: rtl/gmps_chain.sv
// Row chain: a delay line of cells whose length follows the configured column count.
module gmps_chain
#(
    parameter int unsigned MAX_COLS = 1024,
    localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
)
(
    input  logic                           clk,
    input  logic                           shift,
    input  logic [CW-1:0]                  head,
    input  logic [gmps_pkg::SUM_W-1:0]     new_sum,
    output logic [gmps_pkg::SUM_W-1:0]     up_sum
);

    logic [gmps_pkg::SUM_W-1:0] tap [MAX_COLS];

    // The fresh sum enters at the head cell and leaves at the last cell
    // exactly one row of requests later.
    for (genvar k = 0; k < MAX_COLS; k++)
    begin : g_cell
        gmps_pkg::cell_ctl_t        ctl;
        logic [gmps_pkg::SUM_W-1:0] prev;

        assign ctl.shift = shift;
        assign ctl.load  = (head == CW'(k));

        if (k == 0)
        begin : g_first
            assign prev = '0;
        end
        else
        begin : g_rest
            assign prev = tap[k-1];
        end

        gmps_cell u_cell
        (
            .clk      (clk),
            .ctl      (ctl),
            .new_sum  (new_sum),
            .prev_sum (prev),
            .sum      (tap[k])
        );
    end

    assign up_sum = tap[MAX_COLS-1];

endmodule

// File: rtl/grid_min_path_sum.sv
// Top level of the streaming minimum path-sum block over a row-major cost grid.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  cost    | cost_valid, cost_stall, cell_cost        | in
//  sum     | sum_valid, sum_stall, path_sum, grid_end | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// One request is taken per cycle unless the cost side stalls; its result is
// registered in the output register. The previous row's sums travel through a
// chain of MAX_COLS cells, so the sum above is always read at the last cell.
// Reset returns the position to the top-left cell with a 1 x 1 grid.
// The cost side stalls only while a result is held and the sum side stalls.
module grid_min_path_sum
#(
    parameter int unsigned MAX_COLS = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cost_valid,
    output logic                                cost_stall,
    input  logic [gmps_pkg::COST_W-1:0]         cell_cost,
    output logic                                sum_valid,
    input  logic                                sum_stall,
    output logic [gmps_pkg::SUM_W-1:0]          path_sum,
    output logic                                grid_end,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  gmps_pkg::cfg_index_t                cfg_index,
    input  logic [gmps_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "assert_macros.svh"

    localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [CW-1:0] LAST_CELL = CW'(MAX_COLS - 1);

    logic [CW-1:0]                   last_col_reg, last_col_next;
    logic [CW-1:0]                   head_reg, head_next;
    logic [gmps_pkg::ROW_W-1:0]      last_row_reg, last_row_next;
    logic [CW-1:0]                   col_reg, col_next;
    logic [gmps_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [gmps_pkg::SUM_W-1:0]      left_reg, left_next;
    logic                            valid_reg, valid_next;
    logic [gmps_pkg::SUM_W-1:0]      path_sum_reg;
    logic                            grid_end_reg;

    logic                            accept;
    logic                            cfg_write;
    logic [gmps_pkg::SUM_W-1:0]      up_sum;
    logic [gmps_pkg::SUM_W-1:0]      best;
    logic [gmps_pkg::SUM_W:0]        raw_sum;
    logic [gmps_pkg::SUM_W-1:0]      cell_sum;
    logic                            at_last_col;
    logic                            at_last_row;
    logic [gmps_pkg::GCOL_W-1:0]     cols_wr;
    logic [16:0]                     cols_ext;

    assign accept     = cost_valid && !cost_stall;
    assign cost_stall = valid_reg && sum_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;

    // Previous-row sums.
    gmps_chain #(.MAX_COLS(MAX_COLS)) u_chain
    (
        .clk     (clk),
        .shift   (accept),
        .head    (head_reg),
        .new_sum (cell_sum),
        .up_sum  (up_sum)
    );

    // Best predecessor and the saturating sum for the current cell.
    assign at_last_col = (col_reg == last_col_reg);
    assign at_last_row = (row_reg == last_row_reg);

    always_comb
    begin
        if (row_reg == '0 && col_reg == '0)
        begin
            best = '0;
        end
        else if (row_reg == '0)
        begin
            best = left_reg;
        end
        else if (col_reg == '0)
        begin
            best = up_sum;
        end
        else
        begin
            best = (up_sum < left_reg) ? up_sum : left_reg;
        end
    end

    assign raw_sum  = {1'b0, best} + (gmps_pkg::SUM_W + 1)'(cell_cost);
    assign cell_sum = raw_sum[gmps_pkg::SUM_W] ? gmps_pkg::SUM_MAX
                                               : raw_sum[gmps_pkg::SUM_W-1:0];

    // Column count as written, from the low data bits; it is clamped to the chain below.
    assign cols_wr  = cfg_data[gmps_pkg::GCOL_W-1:0];
    assign cols_ext = 17'(cols_wr);

    // Configuration, position counters and the output register's valid bit.
    always_comb
    begin
        last_col_next = last_col_reg;
        head_next     = head_reg;
        last_row_next = last_row_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        left_next     = left_reg;
        valid_next    = valid_reg;

        if (valid_reg && !sum_stall)
        begin
            valid_next = 1'b0;
        end

        if (accept)
        begin
            valid_next = 1'b1;
            left_next  = cell_sum;
            if (at_last_col)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        if (cfg_write)
        begin
            col_next  = '0;
            row_next  = '0;
            left_next = '0;
            case (cfg_index)
                gmps_pkg::CFG_GRID_COLS:
                begin
                    if (cols_wr == '0)
                    begin
                        last_col_next = '0;
                    end
                    else if (cols_ext > 17'(MAX_COLS))
                    begin
                        last_col_next = LAST_CELL;
                    end
                    else
                    begin
                        last_col_next = CW'(cols_ext - 17'd1);
                    end
                    head_next = LAST_CELL - last_col_next;
                end
                gmps_pkg::CFG_GRID_ROWS:
                begin
                    last_row_next = (cfg_data == '0) ? '0 : cfg_data - 1'b1;
                end
                default:
                begin
                    last_row_next = last_row_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= '0;
            head_reg     <= LAST_CELL;
            last_row_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            last_col_reg <= last_col_next;
            head_reg     <= head_next;
            last_row_reg <= last_row_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            left_reg     <= left_next;
            valid_reg    <= valid_next;
        end
    end

    // Result payload, loaded on every accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            path_sum_reg <= cell_sum;
            grid_end_reg <= at_last_col && at_last_row;
        end
    end

    assign sum_valid = valid_reg;
    assign path_sum  = path_sum_reg;
    assign grid_end  = grid_end_reg;

    `GMPS_ALWAYS(a_col_in_row, col_reg <= last_col_reg)
    `GMPS_ALWAYS(a_row_in_grid, row_reg <= last_row_reg)
    `GMPS_NEXT(a_row_wraps, accept && at_last_col, col_reg == '0)
    `GMPS_NEXT(a_end_flagged, accept && at_last_col && at_last_row, sum_valid && grid_end)

endmodule

// File: verif/grid_sum_checker.sv
// Checker for the grid path-sum block: predicts every path sum and compares it.
`timescale 1ns / 100ps

module grid_sum_checker
#(
    parameter int unsigned MAX_COLS = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cost_valid,
    input  logic                                cost_stall,
    input  logic [gmps_pkg::COST_W-1:0]         cell_cost,
    input  logic                                sum_valid,
    input  logic                                sum_stall,
    input  logic [gmps_pkg::SUM_W-1:0]          path_sum,
    input  logic                                grid_end,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  gmps_pkg::cfg_index_t                cfg_index,
    input  logic [gmps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  fail_count,
    output int                                  n_pending
);

    typedef struct packed {
        logic [gmps_pkg::SUM_W-1:0] path_sum;
        logic                       grid_end;
    } cell_result_t;

    // Shadow copy of the configuration and of the walk over the grid.
    logic [gmps_pkg::GCOL_W-1:0] cols_reg;
    logic [gmps_pkg::ROW_W-1:0]  rows_reg;
    logic [gmps_pkg::SUM_W-1:0]  prev_row_sums [MAX_COLS];
    logic [gmps_pkg::SUM_W-1:0]  left_sum;
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    cell_result_t                expected_sums [$];

    initial fail_count = 0;

    function automatic void restart_walk();
        left_sum = '0;
        col_pos  = 0;
        row_pos  = 0;
    endfunction

    // Works out the path sum of the next cell and moves the position on.
    function automatic cell_result_t advance_cell(input logic [gmps_pkg::COST_W-1:0] cost);
        int unsigned                cols;
        int unsigned                rows;
        int unsigned                col;
        int unsigned                row;
        logic [gmps_pkg::SUM_W-1:0] best;
        logic [gmps_pkg::SUM_W:0]   wide;
        cell_result_t               res;
        cols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
        rows = (rows_reg == 0) ? 1 : rows_reg;
        if (col_pos >= cols || row_pos >= rows)
            restart_walk();
        col = col_pos;
        row = row_pos;

        // The top-left cell has no predecessor; the first row and column have one.
        if (row == 0 && col == 0)
            best = '0;
        else if (row == 0)
            best = left_sum;
        else if (col == 0)
            best = prev_row_sums[col];
        else
            best = (prev_row_sums[col] < left_sum) ? prev_row_sums[col] : left_sum;

        // Sums hold at the top of their range rather than wrapping.
        wide = best + cost;
        res.path_sum = wide[gmps_pkg::SUM_W] ? gmps_pkg::SUM_MAX : wide[gmps_pkg::SUM_W-1:0];
        res.grid_end = (row == rows - 1) && (col == cols - 1);
        prev_row_sums[col] = res.path_sum;
        left_sum = res.path_sum;

        if (col + 1 >= cols)
        begin
            col_pos = 0;
            row_pos = (row + 1 >= rows) ? 0 : row + 1;
        end
        else
        begin
            col_pos = col + 1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Results are retired before new requests are predicted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t exp_res;
        if (!rst_n)
        begin
            cols_reg = 11'd1;
            rows_reg = 16'd1;
            restart_walk();
            expected_sums.delete();
            n_pending = 0;
        end
        else
        begin
            if (sum_valid && !sum_stall)
            begin
                if (expected_sums.size() == 0)
                begin
                    report_mismatch($sformatf("path sum %0h with no request waiting", path_sum));
                end
                else
                begin
                    exp_res = expected_sums.pop_front();
                    if (path_sum !== exp_res.path_sum)
                        report_mismatch($sformatf("path_sum expected %0h got %0h",
                                                  exp_res.path_sum, path_sum));
                    if (grid_end !== exp_res.grid_end)
                        report_mismatch($sformatf("grid_end expected %0b got %0b",
                                                  exp_res.grid_end, grid_end));
                end
            end

            // Any register write sends the walk back to the top-left cell.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gmps_pkg::CFG_GRID_COLS: cols_reg = cfg_data[gmps_pkg::GCOL_W-1:0];
                    gmps_pkg::CFG_GRID_ROWS: rows_reg = cfg_data[gmps_pkg::ROW_W-1:0];
                    default: ;
                endcase
                restart_walk();
            end

            if (cost_valid && !cost_stall)
                expected_sums.insert(expected_sums.size(), advance_cell(cell_cost));

            n_pending = expected_sums.size();
        end
    end

endmodule

// File: verif/tb_top.sv
// Top of the grid path-sum testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned MAX_COLS      = 1024;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned SETTLE_CYCLES = 4;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cost_valid;
    logic                              cost_stall;
    logic [gmps_pkg::COST_W-1:0]       cell_cost;
    logic                              sum_valid;
    logic                              sum_stall;
    logic [gmps_pkg::SUM_W-1:0]        path_sum;
    logic                              grid_end;
    logic                              cfg_valid;
    logic                              cfg_ready;
    gmps_pkg::cfg_index_t              cfg_index;
    logic [gmps_pkg::CFG_DATA_W-1:0]   cfg_data;

    int          fail_count;
    int          n_pending;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_len;
    int unsigned quiet_cycles;

    always #5 clk = ~clk;

    grid_min_path_sum #(
        .MAX_COLS (MAX_COLS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cost_valid (cost_valid),
        .cost_stall (cost_stall),
        .cell_cost  (cell_cost),
        .sum_valid  (sum_valid),
        .sum_stall  (sum_stall),
        .path_sum   (path_sum),
        .grid_end   (grid_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    grid_sum_checker #(
        .MAX_COLS (MAX_COLS)
    ) u_sum_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cost_valid (cost_valid),
        .cost_stall (cost_stall),
        .cell_cost  (cell_cost),
        .sum_valid  (sum_valid),
        .sum_stall  (sum_stall),
        .path_sum   (path_sum),
        .grid_end   (grid_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .n_pending  (n_pending)
    );

    // Sum side: random stalls, or one long hold-off when one is asked for.
    initial
    begin
        sum_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                sum_stall <= 1'b1;
                repeat (hold_len - 1) @(negedge clk);
                hold_len = 0;
            end
            else
            begin
                sum_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Ends the run when no channel has moved anything for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cost_valid && !cost_stall) || (sum_valid && !sum_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [gmps_pkg::COST_W-1:0] pick_cost();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return {{(gmps_pkg::COST_W-4){1'b0}}, r[3:0]};
            default: return r[gmps_pkg::COST_W-1:0];
        endcase
    endfunction

    // Offers one cost request, with random idle cycles ahead of it.
    task automatic push_cost(input logic [gmps_pkg::COST_W-1:0] cost);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cost_valid <= 1'b0;
            @(negedge clk);
        end
        cost_valid <= 1'b1;
        cell_cost  <= cost;
        do @(posedge clk); while (cost_stall);
        @(negedge clk);
    endtask

    // Register writes wait until every outstanding sum has come back.
    task automatic write_reg(input gmps_pkg::cfg_index_t idx,
                             input logic [gmps_pkg::CFG_DATA_W-1:0] data);
        cost_valid <= 1'b0;
        while (n_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sets the grid shape and streams a number of cells through it.
    task automatic run_grid(input int unsigned cols_val, input int unsigned rows_val,
                            input int unsigned n_cells, input bit max_cost);
        logic [4:0] junk;
        junk = 5'($urandom_range(31));
        write_reg(gmps_pkg::CFG_GRID_COLS, {junk, cols_val[gmps_pkg::GCOL_W-1:0]});
        write_reg(gmps_pkg::CFG_GRID_ROWS, rows_val[gmps_pkg::ROW_W-1:0]);
        for (int unsigned i = 0; i < n_cells; i++)
            push_cost(max_cost ? '1 : pick_cost());
    endtask

    // Mostly small grids, streamed whole a few times or cut short mid-grid.
    task automatic run_random_grids(input int unsigned n_total);
        int unsigned sent;
        int unsigned cols_val;
        int unsigned rows_val;
        int unsigned cols_e;
        int unsigned rows_e;
        int unsigned n;
        sent = 0;
        while (sent < n_total)
        begin
            case ($urandom_range(19))
                0:       cols_val = $urandom_range(2047, 1000);
                1:       cols_val = 0;
                2, 3:    cols_val = $urandom_range(24, 9);
                default: cols_val = $urandom_range(8, 1);
            endcase
            case ($urandom_range(9))
                0:       rows_val = 0;
                1:       rows_val = 65535;
                default: rows_val = $urandom_range(6, 1);
            endcase
            cols_e = (cols_val == 0) ? 1 : ((cols_val > MAX_COLS) ? MAX_COLS : cols_val);
            rows_e = (rows_val == 0) ? 1 : rows_val;
            if (cols_e * rows_e > 120)
                n = $urandom_range(120, 8);
            else
                n = cols_e * rows_e * $urandom_range(3, 1) + $urandom_range(2, 0);
            if (n > n_total - sent)
                n = n_total - sent;
            run_grid(cols_val, rows_val, n, 1'b0);
            sent += n;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cost_valid    = 1'b0;
        cell_cost     = '0;
        cfg_valid     = 1'b0;
        cfg_index     = gmps_pkg::CFG_GRID_COLS;
        cfg_data      = '0;
        send_idle_pct = 16;
        recv_idle_pct = 58;
        hold_len      = 0;
        quiet_cycles  = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: the 1 x 1 grid out of reset, cost extremes, a 3 x 2 grid.
        push_cost('0);
        push_cost('1);
        write_reg(gmps_pkg::CFG_GRID_COLS, 16'd3);
        write_reg(gmps_pkg::CFG_GRID_ROWS, 16'd2);
        push_cost('1);
        push_cost('0);
        push_cost(16'd1);
        push_cost('0);
        push_cost('1);
        push_cost(16'd2);

        // Zero columns acts as one column; upper data bits are ignored.
        write_reg(gmps_pkg::CFG_GRID_COLS, 16'hF800);
        write_reg(gmps_pkg::CFG_GRID_ROWS, 16'd3);
        push_cost(16'd7);
        push_cost(16'd8);
        push_cost(16'd9);

        // Zero rows acts as one row.
        write_reg(gmps_pkg::CFG_GRID_ROWS, 16'd0);
        write_reg(gmps_pkg::CFG_GRID_COLS, 16'd2);
        push_cost(16'd5);
        push_cost(16'd6);

        // A register write part-way through a grid starts the grid again.
        write_reg(gmps_pkg::CFG_GRID_COLS, 16'd4);
        write_reg(gmps_pkg::CFG_GRID_ROWS, 16'd3);
        repeat (5) push_cost(pick_cost());
        write_reg(gmps_pkg::CFG_GRID_ROWS, 16'd3);
        repeat (4) push_cost(pick_cost());

        // A long hold-off on the sum side while the sender keeps offering,
        // so that the output register fills and the cost side stalls.
        write_reg(gmps_pkg::CFG_GRID_COLS, 16'd5);
        write_reg(gmps_pkg::CFG_GRID_ROWS, 16'd4);
        hold_len = HOLD_CYCLES;
        repeat (20) push_cost(pick_cost());

        // Random grids with the sender idling lightly and the receiver heavily.
        run_random_grids(200);

        send_idle_pct = 58;
        recv_idle_pct = 16;
        run_random_grids(200);

        // No idling: the widest row, clamped from the largest register value.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_grid(2047, 65535, MAX_COLS + 36, 1'b0);

        cost_valid <= 1'b0;
        while (n_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
